>>> src/hbmt_pkg.sv
`timescale 1ns / 1ps

package hbmt_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam logic [30:0] HB_MAX = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_MERGE = 2'd0,
        CMD_SELF  = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_LIST  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_ADDED     = 4'd0,
        ST_REFRESHED = 4'd1,
        ST_IGNORED   = 4'd2,
        ST_FULL      = 4'd3,
        ST_SUSPECTED = 4'd4,
        ST_REMOVED   = 4'd5,
        ST_NOCHANGE  = 4'd6,
        ST_LISTED    = 4'd7,
        ST_SELFBEAT  = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        REG_SELF_ADDRESS  = 2'd0,
        REG_FAIL_TIMEOUT  = 2'd1,
        REG_CLEAN_TIMEOUT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DECIDE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] member_address;
        logic [30:0] heartbeat;
        logic        entry_suspected;
        logic [30:0] now_ticks;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] out_address;
        logic [30:0] out_heartbeat;
        logic [30:0] last_seen;
        logic        out_suspected;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] address;
        logic [30:0] heartbeat;
        logic [30:0] seen_time;
        logic        suspect;
    } entry_t;

    function automatic out_item_t make_result(status_t st, entry_t e);
        out_item_t r;
        r.status        = st;
        r.out_address   = e.address;
        r.out_heartbeat = e.heartbeat;
        r.last_seen     = e.seen_time;
        r.out_suspected = e.suspect;
        r.last          = 1'b0;
        return r;
    endfunction

endpackage

>>> src/heartbeat_membership_table.sv
`timescale 1ns / 1ps

// Membership table of a heartbeat failure detector.
// s_valid/s_ready/s_data carry one command transaction (merge, self beat,
// sweep, list); m_valid/m_ready/m_data return one or more results, the final
// one flagged by last. cfg_wr_en/cfg_index/cfg_wdata write self address,
// fail timeout and clean timeout; write them only while the block is idle.
// Entries live in one memory of MAX_ENTRIES words with a registered read;
// valid bits are flip-flops. Each command walks the table one entry at a
// time (read, then evaluate and write back): a merge or self beat stops at
// the matching entry, a sweep or list always walks the whole table. One item
// is worked at a time; s_ready is high only while idle.
// Results pass through a one-deep holding stage and an output register, so
// the walk goes on while a result waits; with both full it holds until
// m_ready is seen. Reset clears all valid bits and restores the registers
// (self address 0, fail 5, clean 20); no clearing pass is needed.
module heartbeat_membership_table #(
    parameter int MAX_ENTRIES = hbmt_pkg::DEF_MAX_ENTRIES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hbmt_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hbmt_pkg::out_item_t  m_data,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    hbmt_pkg::entry_t mem [MAX_ENTRIES];
    hbmt_pkg::entry_t rdata_reg;

    hbmt_pkg::state_t    state_reg, state_next;
    hbmt_pkg::in_item_t  item_reg, item_next;
    logic signed [33:0]  tf_reg, tf_next, tc_reg, tc_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic                free_found_reg, free_found_next;
    logic                found_reg, found_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    hbmt_pkg::out_item_t pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    hbmt_pkg::out_item_t m_data_reg, m_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         self_addr_reg, self_addr_next;
    logic [15:0]         fail_reg, fail_next, clean_reg, clean_next;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    hbmt_pkg::entry_t    mem_wdata;

    logic                out_free;
    logic                gen;
    hbmt_pkg::out_item_t gen_item;
    logic [31:0]         key;
    hbmt_pkg::entry_t    upd;
    logic signed [33:0]  t_ext;

    assign s_ready  = (state_reg == hbmt_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign t_ext    = $signed({3'b000, rdata_reg.seen_time});

    always_comb begin
        self_addr_next = self_addr_reg;
        fail_next      = fail_reg;
        clean_next     = clean_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                hbmt_pkg::REG_SELF_ADDRESS:  self_addr_next = cfg_wdata;
                hbmt_pkg::REG_FAIL_TIMEOUT:  fail_next = cfg_wdata[15:0];
                hbmt_pkg::REG_CLEAN_TIMEOUT: clean_next = cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hbmt_pkg::S_IDLE: begin
                if (s_valid) state_next = hbmt_pkg::S_READ;
            end
            hbmt_pkg::S_READ: state_next = hbmt_pkg::S_EVAL;
            hbmt_pkg::S_EVAL: begin
                if (item_reg.cmd == hbmt_pkg::CMD_MERGE || item_reg.cmd == hbmt_pkg::CMD_SELF)
                begin
                    if (valid_reg[idx_reg] && rdata_reg.address == key) begin
                        state_next = hbmt_pkg::S_DECIDE;
                    end else if (idx_reg == LAST_IDX) begin
                        state_next = hbmt_pkg::S_DECIDE;
                    end else begin
                        state_next = hbmt_pkg::S_READ;
                    end
                end else if (!(gen && pend_valid_reg && !out_free)) begin
                    state_next = (idx_reg == LAST_IDX) ? hbmt_pkg::S_FINISH
                                                       : hbmt_pkg::S_READ;
                end
            end
            hbmt_pkg::S_DECIDE: state_next = hbmt_pkg::S_FINISH;
            hbmt_pkg::S_FINISH: begin
                if (out_free) state_next = hbmt_pkg::S_IDLE;
            end
            default: state_next = hbmt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        item_next       = item_reg;
        tf_next         = tf_reg;
        tc_next         = tc_reg;
        idx_next        = idx_reg;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        found_next      = found_reg;
        valid_next      = valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rdata_reg;
        gen             = 1'b0;
        gen_item        = '0;
        upd             = rdata_reg;
        key = (item_reg.cmd == hbmt_pkg::CMD_MERGE) ? item_reg.member_address : self_addr_reg;

        case (state_reg)
            hbmt_pkg::S_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    tf_next         = $signed({3'b000, s_data.now_ticks})
                                    - $signed({18'b0, fail_reg});
                    tc_next         = $signed({3'b000, s_data.now_ticks})
                                    - $signed({18'b0, fail_reg})
                                    - $signed({18'b0, clean_reg});
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            hbmt_pkg::S_READ: ;
            hbmt_pkg::S_EVAL: begin
                case (item_reg.cmd)
                    hbmt_pkg::CMD_MERGE, hbmt_pkg::CMD_SELF: begin
                        if (valid_reg[idx_reg] && rdata_reg.address == key) begin
                            found_next = 1'b1;
                        end else begin
                            if (!valid_reg[idx_reg] && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_idx_next   = idx_reg;
                            end
                            if (idx_reg != LAST_IDX) idx_next = idx_reg + 1'b1;
                        end
                    end
                    hbmt_pkg::CMD_SWEEP: begin
                        if (valid_reg[idx_reg]) begin
                            if (tc_reg > t_ext) begin
                                gen      = 1'b1;
                                gen_item = hbmt_pkg::make_result(hbmt_pkg::ST_REMOVED,
                                                                 rdata_reg);
                            end else if (tf_reg > t_ext && !rdata_reg.suspect) begin
                                upd.suspect = 1'b1;
                                gen      = 1'b1;
                                gen_item = hbmt_pkg::make_result(hbmt_pkg::ST_SUSPECTED, upd);
                            end
                        end
                    end
                    default: begin
                        if (valid_reg[idx_reg] && !rdata_reg.suspect) begin
                            gen      = 1'b1;
                            gen_item = hbmt_pkg::make_result(hbmt_pkg::ST_LISTED, rdata_reg);
                        end
                    end
                endcase
                if (item_reg.cmd == hbmt_pkg::CMD_SWEEP || item_reg.cmd == hbmt_pkg::CMD_LIST)
                begin
                    // hold on this entry while both result stages are full
                    if (!(gen && pend_valid_reg && !out_free)) begin
                        if (gen) begin
                            if (pend_valid_reg) begin
                                m_data_next  = pend_reg;
                                m_valid_next = 1'b1;
                            end
                            pend_next       = gen_item;
                            pend_valid_next = 1'b1;
                            if (gen_item.status == hbmt_pkg::ST_REMOVED) begin
                                valid_next[idx_reg] = 1'b0;
                            end else if (gen_item.status == hbmt_pkg::ST_SUSPECTED) begin
                                mem_we    = 1'b1;
                                mem_wdata = upd;
                            end
                        end
                        if (idx_reg != LAST_IDX) idx_next = idx_reg + 1'b1;
                    end
                end
            end
            hbmt_pkg::S_DECIDE: begin
                pend_valid_next = 1'b1;
                if (found_reg) begin
                    mem_waddr = idx_reg;
                    if (item_reg.cmd == hbmt_pkg::CMD_MERGE) begin
                        if (!item_reg.entry_suspected
                                && item_reg.heartbeat > rdata_reg.heartbeat) begin
                            upd.heartbeat = item_reg.heartbeat;
                            upd.seen_time = item_reg.now_ticks;
                            upd.suspect   = 1'b0;
                            mem_we    = 1'b1;
                            mem_wdata = upd;
                            pend_next = hbmt_pkg::make_result(hbmt_pkg::ST_REFRESHED, upd);
                        end else begin
                            pend_next = hbmt_pkg::make_result(hbmt_pkg::ST_IGNORED, rdata_reg);
                        end
                    end else begin
                        if (rdata_reg.heartbeat != hbmt_pkg::HB_MAX) begin
                            upd.heartbeat = rdata_reg.heartbeat + 31'd1;
                        end
                        upd.seen_time = item_reg.now_ticks;
                        mem_we    = 1'b1;
                        mem_wdata = upd;
                        pend_next = hbmt_pkg::make_result(hbmt_pkg::ST_SELFBEAT, upd);
                    end
                end else if (item_reg.cmd == hbmt_pkg::CMD_MERGE && item_reg.entry_suspected)
                begin
                    upd.address   = item_reg.member_address;
                    upd.heartbeat = item_reg.heartbeat;
                    upd.seen_time = '0;
                    upd.suspect   = 1'b0;
                    pend_next = hbmt_pkg::make_result(hbmt_pkg::ST_IGNORED, upd);
                end else if (!free_found_reg) begin
                    upd           = '0;
                    upd.address   = key;
                    pend_next = hbmt_pkg::make_result(hbmt_pkg::ST_FULL, upd);
                end else begin
                    upd.address   = key;
                    upd.heartbeat = (item_reg.cmd == hbmt_pkg::CMD_MERGE) ? item_reg.heartbeat
                                                                          : 31'd1;
                    upd.seen_time = item_reg.now_ticks;
                    upd.suspect   = 1'b0;
                    mem_we    = 1'b1;
                    mem_waddr = free_idx_reg;
                    mem_wdata = upd;
                    valid_next[free_idx_reg] = 1'b1;
                    pend_next = hbmt_pkg::make_result(
                        (item_reg.cmd == hbmt_pkg::CMD_MERGE) ? hbmt_pkg::ST_ADDED
                                                              : hbmt_pkg::ST_SELFBEAT, upd);
                end
            end
            hbmt_pkg::S_FINISH: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        m_data_next = pend_reg;
                    end else begin
                        m_data_next        = '0;
                        m_data_next.status = hbmt_pkg::ST_NOCHANGE;
                    end
                    m_data_next.last = 1'b1;
                    m_valid_next     = 1'b1;
                    pend_valid_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == hbmt_pkg::S_READ) rdata_reg <= mem[idx_reg];
        if (mem_we) mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hbmt_pkg::S_IDLE;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            self_addr_reg  <= 32'd0;
            fail_reg       <= 16'd5;
            clean_reg      <= 16'd20;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            self_addr_reg  <= self_addr_next;
            fail_reg       <= fail_next;
            clean_reg      <= clean_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        tf_reg         <= tf_next;
        tc_reg         <= tc_next;
        idx_reg        <= idx_next;
        free_idx_reg   <= free_idx_next;
        free_found_reg <= free_found_next;
        found_reg      <= found_next;
        pend_reg       <= pend_next;
        m_data_reg     <= m_data_next;
    end

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hbmt_pkg::S_IDLE) |-> !pend_valid_reg)
        else $error("result left pending while idle");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken during a walk");

    a_free_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hbmt_pkg::S_DECIDE && !found_reg && free_found_reg)
        |-> !valid_reg[free_idx_reg])
        else $error("insert slot already occupied");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hbmt_pkg::S_FINISH && out_free) |=> (m_valid && m_data.last))
        else $error("final result not flagged");

endmodule
